// ===== rtl/uvld_pkg.sv =====
// ----------------------------------------------------------------------------
// uvld_pkg
// Types and constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package uvld_pkg;

  localparam int OFFSET_BITS = 16;
  localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int CP_BITS = 21;
  localparam logic [CP_BITS-1:0] CP_MAX       = 21'h10ffff;
  localparam logic [CP_BITS-1:0] SURR_LO      = 21'h00d800;
  localparam logic [CP_BITS-1:0] SURR_HI      = 21'h00dfff;
  localparam logic [CP_BITS-1:0] CP_2BYTE_MIN = 21'h000080;
  localparam logic [CP_BITS-1:0] CP_3BYTE_MIN = 21'h000800;
  localparam logic [CP_BITS-1:0] CP_4BYTE_MIN = 21'h010000;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_TRUNCATED  = 3'd1;
  localparam logic [2:0] ERR_BAD_LEAD   = 3'd2;
  localparam logic [2:0] ERR_INCOMPLETE = 3'd3;
  localparam logic [2:0] ERR_OVERLONG   = 3'd4;
  localparam logic [2:0] ERR_BAD_POINT  = 3'd5;

  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_TRAIL,
    CLS_INVALID
  } byte_cls_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic                   valid_res;
    logic [2:0]             error_code;
    logic [OFFSET_BITS-1:0] error_offset;
  } out_word_t;

  // Classified byte as it travels through the queue.
  typedef struct packed {
    byte_cls_t  cls;
    logic [6:0] bits;
    logic       is_last;
  } cls_word_t;

endpackage

// ===== rtl/uvld_front.sv =====
// ----------------------------------------------------------------------------
// uvld_front
// Classifies each incoming byte as ASCII, a lead, a trail or invalid.
// ----------------------------------------------------------------------------
module uvld_front (
  input  uvld_pkg::in_word_t  in_word,
  output uvld_pkg::cls_word_t cls_word
);
  import uvld_pkg::*;

  logic [7:0] b;

  assign b = in_word.data_byte;

  always_comb begin
    cls_word.is_last = in_word.is_last;
    cls_word.bits    = {1'b0, b[5:0]};
    cls_word.cls     = CLS_INVALID;
    unique casez (b)
      8'b0???????: begin
        cls_word.cls  = CLS_ASCII;
        cls_word.bits = b[6:0];
      end
      8'b10??????: begin
        cls_word.cls  = CLS_TRAIL;
        cls_word.bits = {1'b0, b[5:0]};
      end
      8'b110?????: begin
        cls_word.cls  = CLS_LEAD2;
        cls_word.bits = {2'b00, b[4:0]};
      end
      8'b1110????: begin
        cls_word.cls  = CLS_LEAD3;
        cls_word.bits = {3'b000, b[3:0]};
      end
      8'b11110???: begin
        cls_word.cls  = CLS_LEAD4;
        cls_word.bits = {4'b0000, b[2:0]};
      end
      default: begin
        cls_word.cls  = CLS_INVALID;
        cls_word.bits = 7'd0;
      end
    endcase
  end

endmodule

// ===== rtl/uvld_queue.sv =====
// ----------------------------------------------------------------------------
// uvld_queue
// Short FIFO of classified words between the front and the back.
// ----------------------------------------------------------------------------
module uvld_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  uvld_pkg::cls_word_t push_word,
  input  logic                pop,
  output uvld_pkg::cls_word_t head_word,
  output logic                not_empty,
  output logic                full
);
  import uvld_pkg::*;

  cls_word_t            entry_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r, count_nxt;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign head_word = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ===== rtl/uvld_back.sv =====
// ----------------------------------------------------------------------------
// uvld_back
// Runs the sequence state per classified word and registers the result.
// ----------------------------------------------------------------------------
module uvld_back (
  input  logic                clk,
  input  logic                rst_n,
  input  uvld_pkg::cls_word_t head_word,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output uvld_pkg::out_word_t out_word
);
  import uvld_pkg::*;

  logic [OFFSET_BITS-1:0] position_r, position_nxt;
  logic [OFFSET_BITS-1:0] seq_start_r, seq_start_nxt;
  logic [1:0]             trail_left_r, trail_left_nxt;
  logic [2:0]             seq_len_r, seq_len_nxt;
  logic [CP_BITS-1:0]     partial_r, partial_nxt;
  logic                   fail_r, fail_nxt;
  logic [2:0]             fail_kind_r, fail_kind_nxt;
  logic [OFFSET_BITS-1:0] fail_off_r, fail_off_nxt;

  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_word_r, out_word_nxt;

  logic                   out_free;
  logic [CP_BITS-1:0]     cp;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic                   bad_point;
  logic                   overlong;

  // A result can only be loaded when the output register is free or leaving.
  assign out_free  = !out_valid_r || !out_stall;
  assign pop       = head_valid && (!head_word.is_last || out_free);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign cp      = {partial_r[CP_BITS-7:0], head_word.bits[5:0]};
  assign pos_inc = (position_r != POS_MAX) ? position_r + 1'b1 : position_r;

  assign bad_point = (cp > CP_MAX) || ((cp >= SURR_LO) && (cp <= SURR_HI));
  assign overlong  = ((cp < CP_2BYTE_MIN) && (seq_len_r != LEN_1)) ||
                     ((cp >= CP_2BYTE_MIN) && (cp < CP_3BYTE_MIN) && (seq_len_r != LEN_2)) ||
                     ((cp >= CP_3BYTE_MIN) && (cp < CP_4BYTE_MIN) && (seq_len_r != LEN_3));

  always_comb begin
    position_nxt   = position_r;
    seq_start_nxt  = seq_start_r;
    trail_left_nxt = trail_left_r;
    seq_len_nxt    = seq_len_r;
    partial_nxt    = partial_r;
    fail_nxt       = fail_r;
    fail_kind_nxt  = fail_kind_r;
    fail_off_nxt   = fail_off_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;

    if (pop) begin
      if (!fail_r) begin
        if (trail_left_r == 2'd0) begin
          case (head_word.cls)
            CLS_ASCII: begin
              seq_start_nxt = position_r;
              seq_len_nxt   = LEN_1;
              partial_nxt   = CP_BITS'(head_word.bits);
            end
            CLS_LEAD2: begin
              seq_start_nxt  = position_r;
              seq_len_nxt    = LEN_2;
              trail_left_nxt = 2'd1;
              partial_nxt    = CP_BITS'(head_word.bits);
            end
            CLS_LEAD3: begin
              seq_start_nxt  = position_r;
              seq_len_nxt    = LEN_3;
              trail_left_nxt = 2'd2;
              partial_nxt    = CP_BITS'(head_word.bits);
            end
            CLS_LEAD4: begin
              seq_start_nxt  = position_r;
              seq_len_nxt    = LEN_4;
              trail_left_nxt = 2'd3;
              partial_nxt    = CP_BITS'(head_word.bits);
            end
            default: begin
              fail_nxt      = 1'b1;
              fail_kind_nxt = ERR_BAD_LEAD;
              fail_off_nxt  = position_r;
            end
          endcase
        end else if (head_word.cls != CLS_TRAIL) begin
          fail_nxt       = 1'b1;
          fail_kind_nxt  = ERR_INCOMPLETE;
          fail_off_nxt   = seq_start_r;
          trail_left_nxt = 2'd0;
        end else begin
          partial_nxt    = cp;
          trail_left_nxt = trail_left_r - 1'b1;
          if (trail_left_r == 2'd1) begin
            if (bad_point) begin
              fail_nxt      = 1'b1;
              fail_kind_nxt = ERR_BAD_POINT;
              fail_off_nxt  = seq_start_r;
            end else if (overlong) begin
              fail_nxt      = 1'b1;
              fail_kind_nxt = ERR_OVERLONG;
              fail_off_nxt  = seq_start_r;
            end
          end
        end
      end

      position_nxt = pos_inc;

      if (head_word.is_last) begin
        // A string that ends with trail bytes still owed is truncated.
        if (!fail_nxt && trail_left_nxt != 2'd0) begin
          fail_nxt      = 1'b1;
          fail_kind_nxt = ERR_TRUNCATED;
          fail_off_nxt  = seq_start_nxt;
        end
        out_valid_nxt = 1'b1;
        if (fail_nxt) begin
          out_word_nxt.valid_res    = 1'b0;
          out_word_nxt.error_code   = fail_kind_nxt;
          out_word_nxt.error_offset = fail_off_nxt;
        end else begin
          out_word_nxt.valid_res    = 1'b1;
          out_word_nxt.error_code   = ERR_NONE;
          out_word_nxt.error_offset = pos_inc;
        end
        position_nxt   = '0;
        seq_start_nxt  = '0;
        trail_left_nxt = 2'd0;
        seq_len_nxt    = 3'd0;
        partial_nxt    = '0;
        fail_nxt       = 1'b0;
        fail_kind_nxt  = ERR_NONE;
        fail_off_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      seq_start_r  <= '0;
      trail_left_r <= 2'd0;
      seq_len_r    <= 3'd0;
      partial_r    <= '0;
      fail_r       <= 1'b0;
      fail_kind_r  <= ERR_NONE;
      fail_off_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      position_r   <= position_nxt;
      seq_start_r  <= seq_start_nxt;
      trail_left_r <= trail_left_nxt;
      seq_len_r    <= seq_len_nxt;
      partial_r    <= partial_nxt;
      fail_r       <= fail_nxt;
      fail_kind_r  <= fail_kind_nxt;
      fail_off_r   <= fail_off_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

`ifndef SYNTHESIS
  // A latched failure always abandons the open sequence.
  a_fail_no_trail: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r |-> (trail_left_r == 2'd0))
    else $error("failure latched with trail bytes still owed");

  // The valid flag and the error code must agree.
  a_res_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_word_r.valid_res == (out_word_r.error_code == ERR_NONE)))
    else $error("result flag and error code disagree");

  // The last word of a string leaves the state cleared for the next string.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_word.is_last |=> (position_r == '0) && !fail_r && out_valid_r)
    else $error("state not cleared after last word");

  // A failure stays latched until the string ends.
  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fail_r && !(pop && head_word.is_last) |=> fail_r)
    else $error("latched failure dropped inside a string");
`endif

endmodule

// ===== rtl/utf8_stream_validator.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_validator
// Checks a byte stream for well-formed UTF-8, one string at a time.
// ----------------------------------------------------------------------------
// Usage: send a string one byte per word on the in_ channel with is_last set
// on its final byte. For each such final byte one result word appears on the
// out_ channel: valid_res, the first error code, and the offset of the lead
// byte of the failing sequence (or the string length when the string is
// valid). Offsets saturate at the top of their range. Strings follow each
// other with no gap.
// Throughput is one byte per cycle while in_stall is low. An accepted byte
// is classified by the front and written into a four-word queue; the back
// then pops it, updates the sequence state and, when it is the last byte,
// loads its result into the output register.
// Reset (rst_n low, synchronous) empties the queue, clears the sequence state
// and drops any pending result. When out_stall holds a result, the back keeps
// consuming bytes up to the next last byte, then the queue fills and in_stall
// rises once it is full.
// ----------------------------------------------------------------------------
module utf8_stream_validator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  uvld_pkg::in_word_t  in_payload,
  output logic                out_valid,
  input  logic                out_stall,
  output uvld_pkg::out_word_t out_payload
);
  import uvld_pkg::*;

  cls_word_t cls_word;
  cls_word_t head_word;
  logic      q_full;
  logic      q_not_empty;
  logic      q_pop;
  logic      q_push;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  uvld_front u_front (
    .in_word  (in_payload),
    .cls_word (cls_word)
  );

  uvld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (cls_word),
    .pop       (q_pop),
    .head_word (head_word),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  uvld_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_word  (head_word),
    .head_valid (q_not_empty),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_payload)
  );

endmodule
